// File: sv/aiocl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aiocl_pkg
// Shared widths, register offsets and codes of the coin / lamp I/O registers.
// ----------------------------------------------------------------------------
package aiocl_pkg;

  localparam int DATA_W     = 8;
  localparam int OFS_W      = 11;
  localparam int STR_W      = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam int COIN_SLOTS_DEF = 4;
  localparam int TIME_BITS_DEF  = 48;

  // Bus register offsets
  localparam logic [OFS_W-1:0] OFS_COIN  = 11'h280;
  localparam logic [OFS_W-1:0] OFS_DEVS  = 11'h284;
  localparam logic [OFS_W-1:0] OFS_DUMMY = 11'h288;
  localparam logic [OFS_W-1:0] OFS_OUT   = 11'h28c;

  // Access types
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FFB_MODE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COIN_WINDOW = 4'd1;

  localparam logic [CFG_DATA_W-1:0] COIN_WINDOW_RST = 32'd20000000;
  localparam logic [DATA_W-1:0]     RDATA_UNKNOWN   = 8'hFF;

endpackage : aiocl_pkg
`default_nettype wire

// File: sv/aiocl_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aiocl_req_if
// Bus access channel: one read or write per transfer.
// ----------------------------------------------------------------------------
interface aiocl_req_if
  import aiocl_pkg::*;
#(
  parameter int COIN_SLOTS = COIN_SLOTS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [OFS_W-1:0]      offset;
  logic [DATA_W-1:0]     wdata;
  logic [COIN_SLOTS-1:0] coin_held;
  logic [TIME_BITS-1:0]  now_time;

  modport source (output valid, req_type, offset, wdata, coin_held, now_time, input ready);
  modport sink   (input valid, req_type, offset, wdata, coin_held, now_time, output ready);
endinterface : aiocl_req_if
`default_nettype wire

// File: sv/aiocl_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aiocl_rsp_if
// Result channel: read data, decode status and lamp / force reports.
// ----------------------------------------------------------------------------
interface aiocl_rsp_if
  import aiocl_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] rdata;
  logic              unhandled;
  logic [DATA_W-1:0] lamp_change;
  logic              ffb_valid;
  logic              ffb_negative;
  logic [STR_W-1:0]  ffb_strength;

  modport source (output valid, rdata, unhandled, lamp_change, ffb_valid, ffb_negative,
                  ffb_strength, input ready);
  modport sink   (input valid, rdata, unhandled, lamp_change, ffb_valid, ffb_negative,
                  ffb_strength, output ready);
endinterface : aiocl_rsp_if
`default_nettype wire

// File: sv/aiocl_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aiocl_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface aiocl_cfg_if
  import aiocl_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface : aiocl_cfg_if
`default_nettype wire

// File: sv/arcade_io_coin_lamp_registers_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arcade_io_coin_lamp_registers_core
// Coin, device-type and digital-output registers of an arcade I/O board.
//
//   channel  | dir | payload
//   ---------+-----+-----------------------------------------------------------
//   in_bus   | in  | req_type, offset, wdata, coin_held, now_time
//   out_bus  | out | rdata, unhandled, lamp_change, ffb_valid, ffb_negative,
//            |     | ffb_strength
//   cfg_bus  | in  | index, data (always ready)
//
// One access per cycle while results are taken. An access is captured in the
// input register, then decoded, applied to the state and written to the output
// register together. The output register frees while it is read, so a stalled
// result only holds the input register. Synchronous active-low reset clears all
// control and state and sets the coin window to COIN_WINDOW_RST.
// ----------------------------------------------------------------------------
module arcade_io_coin_lamp_registers_core
  import aiocl_pkg::*;
#(
  parameter int COIN_SLOTS = COIN_SLOTS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  wire           clk,
  input  wire           rst_n,
  aiocl_req_if.sink     in_bus,
  aiocl_rsp_if.source   out_bus,
  aiocl_cfg_if.sink     cfg_bus
);

  localparam int CMP_W = (TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;

  // configuration
  logic                  ffb_mode_r;
  logic [CFG_DATA_W-1:0] coin_window_r;

  // state
  logic                  ram_test_done_r, ram_test_done_nxt;
  logic [3:0]            device_types_r, device_types_nxt;
  logic [COIN_SLOTS-1:0] coin_armed_r, coin_armed_nxt;
  logic [TIME_BITS-1:0]  coin_start_r [COIN_SLOTS];
  logic [TIME_BITS-1:0]  coin_start_nxt [COIN_SLOTS];
  logic [DATA_W-1:0]     output_latch_r, output_latch_nxt;

  // input register
  logic                  in_valid_r;
  logic                  req_type_r;
  logic [OFS_W-1:0]      offset_r;
  logic [DATA_W-1:0]     wdata_r;
  logic [COIN_SLOTS-1:0] coin_held_r;
  logic [TIME_BITS-1:0]  now_time_r;

  // output register
  logic              out_valid_r;
  logic [DATA_W-1:0] rdata_r, rdata_nxt;
  logic              unhandled_r, unhandled_nxt;
  logic [DATA_W-1:0] lamp_change_r, lamp_change_nxt;
  logic              ffb_valid_r, ffb_valid_nxt;
  logic              ffb_negative_r, ffb_negative_nxt;
  logic [STR_W-1:0]  ffb_strength_r, ffb_strength_nxt;

  logic                  advance;
  logic [TIME_BITS-1:0]  elapsed [COIN_SLOTS];
  logic [COIN_SLOTS-1:0] coin_active;
  logic [DATA_W-1:0]     coin_val;

  assign advance       = in_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready  = !in_valid_r || advance;
  assign cfg_bus.ready = 1'b1;

  // coin slot evaluation, one independent compare per slot
  always_comb begin
    coin_val       = '0;
    coin_armed_nxt = coin_armed_r;
    for (int s = 0; s < COIN_SLOTS; s++) begin
      elapsed[s]        = now_time_r - coin_start_r[s];
      coin_start_nxt[s] = coin_start_r[s];
      coin_active[s]    = coin_held_r[s] &&
                          (!coin_armed_r[s] ||
                           (CMP_W'(elapsed[s]) < CMP_W'(coin_window_r)));
      coin_val[s]       = !coin_active[s];
      if (coin_held_r[s]) begin
        if (!coin_armed_r[s]) begin
          coin_armed_nxt[s] = 1'b1;
          coin_start_nxt[s] = now_time_r;
        end
      end else begin
        // release disarms the slot, so the next hold starts a new window
        coin_armed_nxt[s] = 1'b0;
      end
    end
  end

  always_comb begin
    rdata_nxt         = '0;
    unhandled_nxt     = 1'b0;
    lamp_change_nxt   = '0;
    ffb_valid_nxt     = 1'b0;
    ffb_negative_nxt  = 1'b0;
    ffb_strength_nxt  = '0;
    ram_test_done_nxt = ram_test_done_r;
    device_types_nxt  = device_types_r;
    output_latch_nxt  = output_latch_r;
    if (req_type_r == REQ_READ) begin
      case (offset_r)
        OFS_COIN: begin
          ram_test_done_nxt = 1'b1;
          rdata_nxt         = ram_test_done_r ? coin_val : '0;
        end
        OFS_DEVS:  rdata_nxt = {device_types_r, 4'h0};
        OFS_DUMMY: rdata_nxt = '0;
        OFS_OUT:   rdata_nxt = output_latch_r;
        default: begin
          rdata_nxt     = RDATA_UNKNOWN;
          unhandled_nxt = 1'b1;
        end
      endcase
    end else begin
      case (offset_r)
        OFS_DEVS:  device_types_nxt = wdata_r[7:4];
        OFS_DUMMY: device_types_nxt = device_types_r;
        OFS_OUT: begin
          if (wdata_r != output_latch_r) begin
            if (ffb_mode_r) begin
              ffb_valid_nxt    = 1'b1;
              ffb_negative_nxt = wdata_r[0];
              ffb_strength_nxt = wdata_r[4:1];
            end else begin
              lamp_change_nxt = wdata_r ^ output_latch_r;
            end
            output_latch_nxt = wdata_r;
          end
        end
        default: unhandled_nxt = 1'b1;
      endcase
    end
  end

  // coin slots only move on a coin read after the first one
  logic coin_update;
  assign coin_update = advance && (req_type_r == REQ_READ) && (offset_r == OFS_COIN) &&
                       ram_test_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ffb_mode_r      <= 1'b0;
      coin_window_r   <= COIN_WINDOW_RST;
      ram_test_done_r <= 1'b0;
      device_types_r  <= '0;
      coin_armed_r    <= '0;
      output_latch_r  <= '0;
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      for (int s = 0; s < COIN_SLOTS; s++) begin
        coin_start_r[s] <= '0;
      end
    end else begin
      if (cfg_bus.valid) begin
        case (cfg_bus.index)
          CFG_FFB_MODE:    ffb_mode_r    <= cfg_bus.data[0];
          CFG_COIN_WINDOW: coin_window_r <= cfg_bus.data;
          default: ffb_mode_r <= ffb_mode_r;
        endcase
      end
      if (in_bus.ready) begin
        in_valid_r <= in_bus.valid;
      end
      if (advance) begin
        out_valid_r     <= 1'b1;
        ram_test_done_r <= ram_test_done_nxt;
        device_types_r  <= device_types_nxt;
        output_latch_r  <= output_latch_nxt;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      if (coin_update) begin
        coin_armed_r <= coin_armed_nxt;
        for (int s = 0; s < COIN_SLOTS; s++) begin
          coin_start_r[s] <= coin_start_nxt[s];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      req_type_r  <= in_bus.req_type;
      offset_r    <= in_bus.offset;
      wdata_r     <= in_bus.wdata;
      coin_held_r <= in_bus.coin_held;
      now_time_r  <= in_bus.now_time;
    end
    if (advance) begin
      rdata_r        <= rdata_nxt;
      unhandled_r    <= unhandled_nxt;
      lamp_change_r  <= lamp_change_nxt;
      ffb_valid_r    <= ffb_valid_nxt;
      ffb_negative_r <= ffb_negative_nxt;
      ffb_strength_r <= ffb_strength_nxt;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.rdata        = rdata_r;
  assign out_bus.unhandled    = unhandled_r;
  assign out_bus.lamp_change  = lamp_change_r;
  assign out_bus.ffb_valid    = ffb_valid_r;
  assign out_bus.ffb_negative = ffb_negative_r;
  assign out_bus.ffb_strength = ffb_strength_r;

endmodule : arcade_io_coin_lamp_registers_core
`default_nettype wire

// File: tb/sv/tb_arcade_io_coin_lamp_registers_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arcade_io_coin_lamp_registers_core
// Self-checking bench for the coin / lamp I/O register block.
//
// A directed table checks reset values, decode and the coin ram-test answer.
// Random bus traffic then runs under several ffb_mode / coin_window settings.
// Every access is scored against a fixed table result or an in-bench model of the
// registers. The sender runs in bursts and the receiver stalls in its own patterns.
// ----------------------------------------------------------------------------
module tb_arcade_io_coin_lamp_registers_core
  import aiocl_pkg::*;
;

  localparam int SLOTS    = COIN_SLOTS_DEF;
  localparam int TBITS    = TIME_BITS_DEF;
  localparam int WATCHDOG = 2000;
  localparam int N_PHASES = 5;

  typedef struct packed {
    logic             req_type;
    logic [OFS_W-1:0] offset;
    logic [DATA_W-1:0] wdata;
    logic [SLOTS-1:0] coin_held;
    logic [TBITS-1:0] now_time;
  } bus_access_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              unhandled;
    logic [DATA_W-1:0] lamp_change;
    logic              ffb_valid;
    logic              ffb_negative;
    logic [STR_W-1:0]  ffb_strength;
  } bus_result_t;

  typedef struct packed {
    bus_access_t acc;
    logic        typed;
    bus_result_t res;
  } dir_row_t;

  localparam bus_result_t NO_RESULT = '0;
  localparam bus_result_t RD_UNKNOWN = '{RDATA_UNKNOWN, 1'b1, 8'h00, 1'b0, 1'b0, 4'h0};
  localparam bus_result_t WR_UNKNOWN = '{8'h00, 1'b1, 8'h00, 1'b0, 1'b0, 4'h0};

  logic clk = 1'b0;
  logic rst_n;

  aiocl_req_if #(.COIN_SLOTS(SLOTS), .TIME_BITS(TBITS)) req_bus();
  aiocl_rsp_if rsp_bus();
  aiocl_cfg_if cfg_bus();

  arcade_io_coin_lamp_registers_core #(
    .COIN_SLOTS(SLOTS),
    .TIME_BITS (TBITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (req_bus),
    .out_bus(rsp_bus),
    .cfg_bus(cfg_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register model state and configuration mirror
  logic             mir_ffb;
  logic [31:0]      mir_window;
  logic             first_coin_read_done;
  logic [3:0]       dev_nibble;
  logic [SLOTS-1:0] slot_armed;
  logic [TBITS-1:0] slot_t0 [SLOTS];
  logic [7:0]       lamp_latch;

  bus_result_t want_q[$];

  int errs = 0;
  int n_items = 0;
  int n_results = 0;
  int n_coin_rd = 0;
  int n_unh = 0;
  int n_lamp = 0;
  int n_ffb = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;

  logic [TBITS-1:0] bus_time;
  logic [SLOTS-1:0] held_now;

  // Directed accesses, all under the reset configuration
  dir_row_t dir_tab [0:23] = '{
    '{'{REQ_READ,  OFS_COIN,  8'h00, 4'hF, 48'd0},  1'b1, NO_RESULT},  // ram-test skip
    '{'{REQ_READ,  OFS_COIN,  8'h00, 4'hF, 48'd5},  1'b1, NO_RESULT},  // all coins armed
    '{'{REQ_READ,  OFS_DEVS,  8'h00, 4'h0, 48'd6},  1'b1, NO_RESULT},
    '{'{REQ_WRITE, OFS_DEVS,  8'hFF, 4'h0, 48'd7},  1'b1, NO_RESULT},
    '{'{REQ_READ,  OFS_DEVS,  8'h00, 4'h0, 48'd8},  1'b1,
      '{8'hF0, 1'b0, 8'h00, 1'b0, 1'b0, 4'h0}},
    '{'{REQ_WRITE, OFS_DEVS,  8'h0F, 4'h0, 48'd9},  1'b1, NO_RESULT},
    '{'{REQ_READ,  OFS_DEVS,  8'h00, 4'h0, 48'd10}, 1'b1, NO_RESULT},
    '{'{REQ_READ,  OFS_DUMMY, 8'h00, 4'h0, 48'd11}, 1'b1, NO_RESULT},
    '{'{REQ_WRITE, OFS_DUMMY, 8'hAA, 4'h0, 48'd12}, 1'b1, NO_RESULT},
    '{'{REQ_READ,  OFS_OUT,   8'h00, 4'h0, 48'd13}, 1'b1, NO_RESULT},
    '{'{REQ_WRITE, OFS_OUT,   8'hFF, 4'h0, 48'd14}, 1'b1,
      '{8'h00, 1'b0, 8'hFF, 1'b0, 1'b0, 4'h0}},
    '{'{REQ_WRITE, OFS_OUT,   8'hFF, 4'h0, 48'd15}, 1'b1, NO_RESULT},  // unchanged
    '{'{REQ_WRITE, OFS_OUT,   8'h00, 4'h0, 48'd16}, 1'b1,
      '{8'h00, 1'b0, 8'hFF, 1'b0, 1'b0, 4'h0}},
    '{'{REQ_READ,  11'h000,   8'h00, 4'h0, 48'd17}, 1'b1, RD_UNKNOWN},
    '{'{REQ_READ,  11'h7FF,   8'h00, 4'h0, 48'd18}, 1'b1, RD_UNKNOWN},
    '{'{REQ_WRITE, 11'h7FF,   8'h55, 4'h0, 48'd19}, 1'b1, WR_UNKNOWN},
    '{'{REQ_WRITE, OFS_COIN,  8'h5A, 4'hF, 48'd20}, 1'b1, WR_UNKNOWN},
    // window edge: last cycle inside, first cycle outside, then re-arm
    '{'{REQ_READ,  OFS_COIN,  8'h00, 4'h5, 48'd20000004}, 1'b0, NO_RESULT},
    '{'{REQ_READ,  OFS_COIN,  8'h00, 4'h5, 48'd20000005}, 1'b0, NO_RESULT},
    '{'{REQ_READ,  OFS_COIN,  8'h00, 4'hA, 48'd20000006}, 1'b0, NO_RESULT},
    '{'{REQ_WRITE, OFS_OUT,   8'h3C, 4'h0, 48'd20000007}, 1'b0, NO_RESULT},
    '{'{REQ_READ,  OFS_OUT,   8'h00, 4'h0, 48'd20000008}, 1'b0, NO_RESULT},
    // timestamp wraps between sighting and next read
    '{'{REQ_READ,  OFS_COIN,  8'h00, 4'h1, 48'hFFFF_FFFF_FFF0}, 1'b0, NO_RESULT},
    '{'{REQ_READ,  OFS_COIN,  8'h00, 4'h1, 48'h0000_0000_0010}, 1'b0, NO_RESULT}
  };

  logic             ph_ffb  [N_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  logic [31:0]      ph_win  [N_PHASES] = '{32'd1, 32'd100, 32'hFFFF_FFFF, 32'd1000,
                                           COIN_WINDOW_RST};
  int unsigned      ph_step [N_PHASES] = '{2, 60, 32'h1000_0000, 400, 8000000};
  logic [TBITS-1:0] ph_t0   [N_PHASES] = '{48'd1000, 48'd0, 48'd0,
                                           48'hFFFF_FFFF_F000, 48'd0};

  // Applies one access to the register model and returns its result
  function automatic bus_result_t next_bus_result(input bus_access_t a);
    bus_result_t      r;
    logic [SLOTS-1:0] coin_n;
    logic [TBITS-1:0] elapsed;
    r = '0;
    if (a.req_type == REQ_READ) begin
      case (a.offset)
        OFS_COIN: begin
          if (!first_coin_read_done) begin
            first_coin_read_done = 1'b1;
          end else begin
            coin_n = '1;
            for (int s = 0; s < SLOTS; s++) begin
              if (a.coin_held[s]) begin
                elapsed = a.now_time - slot_t0[s];
                if (!slot_armed[s] || elapsed < mir_window) begin
                  if (!slot_armed[s]) begin
                    slot_armed[s] = 1'b1;
                    slot_t0[s]    = a.now_time;
                  end
                  coin_n[s] = 1'b0;
                end
              end else begin
                slot_armed[s] = 1'b0;
                slot_t0[s]    = '0;
              end
            end
            r.rdata = DATA_W'(coin_n);
          end
        end
        OFS_DEVS:  r.rdata = {dev_nibble, 4'h0};
        OFS_DUMMY: r.rdata = 8'h00;
        OFS_OUT:   r.rdata = lamp_latch;
        default: begin
          r.rdata     = RDATA_UNKNOWN;
          r.unhandled = 1'b1;
        end
      endcase
    end else begin
      case (a.offset)
        OFS_DEVS:  dev_nibble = a.wdata[7:4];
        OFS_DUMMY: r.rdata = 8'h00;
        OFS_OUT: begin
          if (a.wdata != lamp_latch) begin
            if (mir_ffb) begin
              r.ffb_valid    = 1'b1;
              r.ffb_negative = a.wdata[0];
              r.ffb_strength = a.wdata[4:1];
            end else begin
              r.lamp_change = a.wdata ^ lamp_latch;
            end
            lamp_latch = a.wdata;
          end
        end
        default: r.unhandled = 1'b1;
      endcase
    end
    return r;
  endfunction

  // Offers one access, waits for its transfer, queues the expected result
  task automatic drive_access(input bus_access_t a, input logic typed, input bus_result_t fixed);
    bus_result_t pred;
    req_bus.valid     <= 1'b1;
    req_bus.req_type  <= a.req_type;
    req_bus.offset    <= a.offset;
    req_bus.wdata     <= a.wdata;
    req_bus.coin_held <= a.coin_held;
    req_bus.now_time  <= a.now_time;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    pred = next_bus_result(a);
    want_q.push_back(typed ? fixed : pred);
    n_items++;
    if (a.req_type == REQ_READ && a.offset == OFS_COIN) n_coin_rd++;
    if (pred.unhandled) n_unh++;
    if (pred.lamp_change != 8'h00) n_lamp++;
    if (pred.ffb_valid) n_ffb++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic drain();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == CFG_FFB_MODE) mir_ffb = val[0];
    else if (idx == CFG_COIN_WINDOW) mir_window = val;
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly known registers with coins held across many reads; some noise
  task automatic run_traffic(input int n, input int unsigned step_max);
    bus_access_t a;
    int          pick;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) held_now ^= SLOTS'(1 << $urandom_range(0, SLOTS - 1));
      bus_time    += $urandom_range(0, step_max);
      a.req_type  = REQ_READ;
      a.offset    = OFS_COIN;
      a.wdata     = 8'($urandom);
      a.coin_held = held_now;
      a.now_time  = bus_time;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        a.offset = OFS_COIN;
      end else if (pick < 50) begin
        a.offset   = OFS_DEVS;
        a.req_type = 1'($urandom_range(0, 1));
      end else if (pick < 55) begin
        a.offset   = OFS_DUMMY;
        a.req_type = 1'($urandom_range(0, 1));
      end else if (pick < 80) begin
        a.offset   = OFS_OUT;
        a.req_type = ($urandom_range(0, 3) != 0) ? REQ_WRITE : REQ_READ;
        if ($urandom_range(0, 3) == 0) a.wdata = lamp_latch;
      end else if (pick < 85) begin
        a.offset   = OFS_COIN;
        a.req_type = REQ_WRITE;
      end else begin
        a.req_type  = 1'($urandom_range(0, 1));
        a.offset    = OFS_W'($urandom);
        a.coin_held = SLOTS'($urandom);
        if ($urandom_range(0, 1) == 0) a.now_time = {16'($urandom), 32'($urandom)};
      end
      drive_access(a, 1'b0, NO_RESULT);
    end
  endtask

  // Receiver: random, patterned and free-running stretches plus a long hold
  initial begin
    int seg_left;
    int mode;
    int hold_left;
    seg_left  = 0;
    mode      = 0;
    hold_left = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = 80;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 2);
          seg_left = $urandom_range(16, 96);
        end
        seg_left--;
        case (mode)
          0:       rsp_bus.ready <= 1'b1;
          1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
          default: rsp_bus.ready <= (seg_left % 5 != 0);
        endcase
      end
    end
  end

  // Result scoreboard
  always @(posedge clk) begin
    bus_result_t got;
    bus_result_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      n_results++;
      got = '{rsp_bus.rdata, rsp_bus.unhandled, rsp_bus.lamp_change, rsp_bus.ffb_valid,
              rsp_bus.ffb_negative, rsp_bus.ffb_strength};
      if (want_q.size() == 0) begin
        errs++;
        if (errs <= 10)
          $display("%0t: result with nothing expected, rdata %h", $realtime, got.rdata);
      end else begin
        want = want_q.pop_front();
        if (got !== want) begin
          errs++;
          if (errs <= 10) begin
            $write("%0t: mismatch (exp/act) rdata %h/%h unh %b/%b lamp %h/%h",
                   $realtime, want.rdata, got.rdata, want.unhandled, got.unhandled,
                   want.lamp_change, got.lamp_change);
            $display(" ffb %b/%b neg %b/%b str %h/%h",
                     want.ffb_valid, got.ffb_valid, want.ffb_negative, got.ffb_negative,
                     want.ffb_strength, got.ffb_strength);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout: no transfer for %0d cycles, %0d results pending",
               WATCHDOG, want_q.size());
      $display("** arcade_io_coin_lamp_registers_core: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    req_bus.valid     <= 1'b0;
    req_bus.req_type  <= REQ_READ;
    req_bus.offset    <= '0;
    req_bus.wdata     <= '0;
    req_bus.coin_held <= '0;
    req_bus.now_time  <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= CFG_FFB_MODE;
    cfg_bus.data      <= '0;
    mir_ffb              = 1'b0;
    mir_window           = COIN_WINDOW_RST;
    first_coin_read_done = 1'b0;
    dev_nibble           = 4'h0;
    slot_armed           = '0;
    lamp_latch           = 8'h00;
    for (int s = 0; s < SLOTS; s++) slot_t0[s] = '0;
    held_now = '0;
    bus_time = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 24; i++) drive_access(dir_tab[i].acc, dir_tab[i].typed, dir_tab[i].res);

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      set_cfg(CFG_FFB_MODE, {31'b0, ph_ffb[p]});
      set_cfg(CFG_COIN_WINDOW, ph_win[p]);
      bus_time = (p == N_PHASES - 1) ? {16'($urandom), 32'($urandom)} : ph_t0[p];
      if (p == 0) begin
        run_traffic(90, ph_step[p]);
        hold_req = 1'b1;  // receiver holds off while the sender keeps offering
        run_traffic(95, ph_step[p]);
      end else if (p == 1) begin
        run_traffic(90, ph_step[p]);
        drain();
        run_traffic(95, ph_step[p]);
      end else begin
        run_traffic(185, ph_step[p]);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    errs += want_q.size();

    $display("covered %0d accesses: %0d coin reads, %0d unhandled, %0d lamp, %0d force reports",
             n_items, n_coin_rd, n_unh, n_lamp, n_ffb);
    $display("%0d configuration settings, %0d results checked, %0d errors",
             N_PHASES + 1, n_results, errs);
    if (errs == 0) begin
      $display("** arcade_io_coin_lamp_registers_core: PASSED **");
    end else begin
      $display("** arcade_io_coin_lamp_registers_core: FAILED **");
    end
    $finish;
  end

endmodule
